// ===== src/tdf_pkg.sv =====
// tdf_pkg: shared types and constants for the timed duplicate filter
// used by tdf_cell and timed_duplicate_filter; no dependencies

package tdf_pkg;

  localparam int unsigned HASH_W     = 32;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned WINDOW_W   = 32;
  // slot index wide enough for the largest table (256 slots)
  localparam int unsigned SLOT_IDX_W = 8;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd120000;

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;
  typedef logic [HASH_W-1:0]     hash_t;
  typedef logic [TIME_W-1:0]     stamp_t;
  typedef logic [WINDOW_W-1:0]   window_t;

  typedef enum logic [1:0] {
    ACT_DUP     = 2'd0,
    ACT_REFRESH = 2'd1,
    ACT_REPLACE = 2'd2
  } action_t;

  // lookup word walking down the cell chain
  typedef struct packed {
    logic      valid;
    hash_t     key;
    stamp_t    now;
    logic      dup;       // young match seen so far
    logic      hit;       // any match seen so far
    slot_idx_t hit_idx;   // first matching slot
    slot_idx_t old_idx;   // oldest slot so far, lowest index on a tie
    stamp_t    old_time;
  } token_t;

  // table update broadcast to all cells
  typedef struct packed {
    logic      en;
    slot_idx_t idx;
    hash_t     hash;
    stamp_t    stamp;
  } wr_t;

endpackage

// ===== src/tdf_cell.sv =====
// tdf_cell: one table slot plus one stage of the lookup chain
// depends on tdf_pkg

module tdf_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  tdf_pkg::window_t window,
  input  tdf_pkg::token_t  tok_in,
  input  tdf_pkg::wr_t     wr,
  output tdf_pkg::token_t  tok_out
);

  tdf_pkg::hash_t  entry_hash;
  tdf_pkg::stamp_t entry_time;
  tdf_pkg::token_t tok_next;

  logic match;
  logic young;
  logic older;

  always_comb begin
    match = (entry_hash == tok_in.key);
    // time running backwards counts as age zero
    if (tok_in.now >= entry_time) begin
      young = ((tok_in.now - entry_time) < {16'd0, window});
    end else begin
      young = (window != '0);
    end
    older = (IDX == 0) || (entry_time < tok_in.old_time);

    tok_next = tok_in;
    tok_next.dup = tok_in.dup | (match & young);
    if (match && !tok_in.hit) begin
      tok_next.hit     = 1'b1;
      tok_next.hit_idx = tdf_pkg::slot_idx_t'(IDX);
    end
    if (older) begin
      tok_next.old_idx  = tdf_pkg::slot_idx_t'(IDX);
      tok_next.old_time = entry_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out    <= '0;
      entry_hash <= '0;
      entry_time <= '0;
    end else begin
      tok_out <= tok_next;
      if (wr.en && (wr.idx == tdf_pkg::slot_idx_t'(IDX))) begin
        entry_hash <= wr.hash;
        entry_time <= wr.stamp;
      end
    end
  end

endmodule

// ===== src/timed_duplicate_filter.sv =====
// timed_duplicate_filter: time-windowed duplicate suppression over a row of slots
// depends on tdf_pkg and tdf_cell
//
// flow: the lookup word walks one cell per cycle down the chain; on exit the decision is
//   registered (BUSY to DONE) and handed off once the output is free; a new word is
//   accepted only back in IDLE, after the previous result has been handed off
// reset: table cleared to hash 0 / time 0, window back to 120000 ms

module timed_duplicate_filter #(
  parameter int unsigned SLOTS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // window register write
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // input words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // [31:0] key_hash, [79:32] now_ms
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // [0] duplicate, [2:1] action, [7:3] zero
);

  typedef enum logic [1:0] {
    IDLE,
    BUSY,
    DONE
  } state_t;

  state_t state;

  tdf_pkg::window_t window;

  // tok[0] feeds cell 0, tok[i+1] is the output of cell i
  tdf_pkg::token_t tok [SLOTS+1];
  logic [SLOTS-1:0] tok_valid;
  tdf_pkg::wr_t     wr;

  // decision held between chain exit and result hand-off
  logic               pend_dup;
  tdf_pkg::action_t   pend_act;
  tdf_pkg::slot_idx_t pend_idx;
  tdf_pkg::hash_t     pend_key;
  tdf_pkg::stamp_t    pend_now;

  logic accept;
  logic out_free;

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  // window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= tdf_pkg::WINDOW_RESET;
    end else if (cfg_wr_en) begin
      window <= cfg_wr_data;
    end
  end

  // lookup word injected into the head of the chain
  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = accept;
    tok[0].key      = s_tdata[31:0];
    tok[0].now      = s_tdata[79:32];
  end

  // the chain: one cell per slot, each registers the word on to its neighbor
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    tdf_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .window  (window),
      .tok_in  (tok[i]),
      .wr      (wr),
      .tok_out (tok[i+1])
    );
    assign tok_valid[i] = tok[i+1].valid;
  end

  // table update lands in the same edge as the result hand-off; duplicates leave it alone
  always_comb begin
    wr.en    = (state == DONE) && out_free && !pend_dup;
    wr.idx   = pend_idx;
    wr.hash  = pend_key;
    wr.stamp = pend_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      pend_dup <= 1'b0;
      pend_act <= tdf_pkg::ACT_DUP;
      pend_idx <= '0;
      pend_key <= '0;
      pend_now <= '0;
    end else begin
      // in DONE the hand-off below owns m_tvalid
      if (m_tvalid && m_tready && (state != DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            state <= BUSY;
          end
        end
        BUSY: begin
          // word leaves the last cell with the whole table summarized
          if (tok[SLOTS].valid) begin
            pend_key <= tok[SLOTS].key;
            pend_now <= tok[SLOTS].now;
            pend_dup <= tok[SLOTS].dup;
            if (tok[SLOTS].dup) begin
              pend_act <= tdf_pkg::ACT_DUP;
              pend_idx <= tok[SLOTS].hit_idx;
            end else if (tok[SLOTS].hit) begin
              pend_act <= tdf_pkg::ACT_REFRESH;
              pend_idx <= tok[SLOTS].hit_idx;
            end else begin
              pend_act <= tdf_pkg::ACT_REPLACE;
              pend_idx <= tok[SLOTS].old_idx;
            end
            state <= DONE;
          end
        end
        DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'd0, pend_act, pend_dup};
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // only one lookup word in flight
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_valid) <= 1)
    else $error("more than one lookup word in the chain");

  // an accepted word enters cell 0 on the next edge
  a_enter_chain: assert property (@(posedge clk) disable iff (rst)
    accept |=> tok[1].valid)
    else $error("accepted word did not enter the chain");

  // the chain only carries a word while the controller waits for it
  a_exit_busy: assert property (@(posedge clk) disable iff (rst)
    tok[SLOTS].valid |-> (state == BUSY))
    else $error("lookup word left the chain outside BUSY");

  // duplicate flag agrees with the action code
  a_dup_action: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == tdf_pkg::ACT_DUP)))
    else $error("duplicate flag and action disagree");

  // no table write while a lookup is still walking the chain
  a_write_quiet: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (tok_valid == '0))
    else $error("table written during a lookup");
`endif

endmodule
